// File: rtl/partition_refinement_table_assert.svh
// assertion macros used by partition_refinement_table.sv
`ifndef PARTITION_REFINEMENT_TABLE_ASSERT_SVH
`define PARTITION_REFINEMENT_TABLE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define PRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define PRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/prt_pkg.sv
package prt_pkg;

    localparam int OPCODE_W     = 2;
    localparam int ELEM_W       = 10;
    localparam int POS_W        = 10;
    localparam int END_W        = 11;
    localparam int PIVOT_W      = 11;
    localparam int DEF_ELEMENTS = 1024;

    localparam logic [OPCODE_W-1:0] OP_PLACE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MARK  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ELEM_W-1:0]   element;
        logic [POS_W-1:0]    position;
        logic [END_W-1:0]    range_end;
    } t_in_item;

    typedef struct packed {
        logic [PIVOT_W-1:0] pivot;
        logic               moved;
    } t_out_item;

endpackage

// File: rtl/partition_refinement_table.sv
// Partition refinement table: element_at_position and position_of_element live in two
// single-port-read, single-port-write rams of ELEMENTS entries, and the block begin and
// split point live in registers. A place or start item, and the unused opcode, is done
// in the idle state; a mark item goes through a position lookup, then a read of the entry
// at the old position while the first half of the swap is written, then the second half
// of the swap, an order set by the element ram's one read port and its registered read.
// One item is in flight at a time; a finished result sits in the output register, and a
// new transfer is taken while it waits. The rams have no reset and no clearing pass: an
// entry must be placed before it is looked up. Every item answers with the split point.
`include "partition_refinement_table_assert.svh"

module partition_refinement_table
    import prt_pkg::*;
#(
    parameter int ELEMENTS = DEF_ELEMENTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(ELEMENTS);
    localparam int SW = $clog2(ELEMENTS + 1);

    // one-hot sequencer
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SWAP = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [SW-1:0]    r_split, n_split;
    logic [POS_W-1:0] r_begin, n_begin;

    // mark item context
    logic          r_elem_ok, n_elem_ok;
    logic [AW-1:0] r_pb, n_pb;
    logic [AW-1:0] r_eb, n_eb;
    logic          r_hit, n_hit;

    // result waiting for the output register, and the output register
    t_out_item r_res, n_res;
    t_out_item r_out, n_out;
    logic      r_out_valid, n_out_valid;

    // ram ports
    logic          elem_we, pos_we;
    logic [AW-1:0] elem_waddr, elem_wdata, elem_raddr, elem_rdata;
    logic [AW-1:0] pos_waddr, pos_wdata, pos_raddr, pos_rdata;

    logic      acc_in, slot_free, place_ok, hit_now;
    logic [SW-1:0] sat_end;
    t_out_item res;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign acc_in    = i_in_valid && o_in_ready;
    // output register free for a new result this cycle
    assign slot_free = !r_out_valid || i_out_ready;

    assign place_ok = (32'(i_in_data.element) < ELEMENTS) &&
                      (32'(i_in_data.position) < ELEMENTS);
    // block end beyond the table saturates to the table size
    assign sat_end  = (32'(i_in_data.range_end) > ELEMENTS) ? SW'(ELEMENTS)
                                                            : SW'(i_in_data.range_end);
    // marked element sits inside [begin, split)
    assign hit_now  = r_elem_ok && (32'(r_begin) <= 32'(pos_rdata)) &&
                      (32'(pos_rdata) < 32'(r_split));

    always_comb begin
        n_state     = r_state;
        n_split     = r_split;
        n_begin     = r_begin;
        n_elem_ok   = r_elem_ok;
        n_pb        = r_pb;
        n_eb        = r_eb;
        n_hit       = r_hit;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        elem_we    = 1'b0;
        elem_waddr = AW'(i_in_data.position);
        elem_wdata = AW'(i_in_data.element);
        elem_raddr = AW'(r_split - 1'b1);
        pos_we     = 1'b0;
        pos_waddr  = AW'(i_in_data.element);
        pos_wdata  = AW'(i_in_data.position);
        pos_raddr  = AW'(i_in_data.element);

        res.pivot = PIVOT_W'(r_split);
        res.moved = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    if (i_in_data.opcode == OP_PLACE) begin
                        elem_we = place_ok;
                        pos_we  = place_ok;
                    end else if (i_in_data.opcode == OP_START) begin
                        n_begin   = i_in_data.position;
                        n_split   = sat_end;
                        res.pivot = PIVOT_W'(sat_end);
                    end
                    if (i_in_data.opcode == OP_MARK) begin
                        // position lookup and read of the entry at split - 1 go out together
                        n_elem_ok = 32'(i_in_data.element) < ELEMENTS;
                        n_pb      = AW'(r_split - 1'b1);
                        n_state   = S_READ;
                    end else if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_out       = res;
                    end else begin
                        n_res   = res;
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: begin
                // first half of the swap: element at split - 1 goes to the old position
                n_hit      = hit_now;
                n_eb       = elem_rdata;
                elem_raddr = pos_rdata;
                elem_we    = hit_now;
                elem_waddr = pos_rdata;
                elem_wdata = elem_rdata;
                pos_we     = hit_now;
                pos_waddr  = elem_rdata;
                pos_wdata  = pos_rdata;
                if (hit_now) begin
                    n_split = r_split - 1'b1;
                end
                n_state = S_SWAP;
            end
            S_SWAP: begin
                // second half: the old occupant (read-first data) goes to the new split
                elem_we    = r_hit;
                elem_waddr = r_pb;
                elem_wdata = elem_rdata;
                // same element at both ends keeps the position from the first half
                pos_we     = r_hit && (elem_rdata != r_eb);
                pos_waddr  = elem_rdata;
                pos_wdata  = r_pb;
                res.moved  = r_hit;
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = res;
                    n_state     = S_IDLE;
                end else begin
                    n_res   = res;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_split     <= '0;
            r_begin     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_split     <= n_split;
            r_begin     <= n_begin;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and mark context, no reset needed
    always_ff @(posedge i_clk) begin
        r_elem_ok <= n_elem_ok;
        r_pb      <= n_pb;
        r_eb      <= n_eb;
        r_hit     <= n_hit;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    prt_ram #(
        .WIDTH (AW),
        .DEPTH (ELEMENTS)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (elem_waddr),
        .i_wdata (elem_wdata),
        .i_raddr (elem_raddr),
        .o_rdata (elem_rdata)
    );

    prt_ram #(
        .WIDTH (AW),
        .DEPTH (ELEMENTS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    `PRT_ASSERT_NEXT(a_mark_goes_to_read, acc_in && (i_in_data.opcode == OP_MARK), r_state == S_READ, "mark transfer did not start the lookup")
    `PRT_ASSERT_NEXT(a_hit_drops_split, (r_state == S_READ) && hit_now, r_split == $past(r_split) - 1'b1, "split point not decremented on a hit")
    `PRT_ASSERT_NOW(a_split_in_table, 1'b1, 32'(r_split) <= ELEMENTS, "split point beyond table")
    `PRT_ASSERT_NOW(a_swap_writes_elem, (r_state == S_SWAP) && r_hit, elem_we, "swap second half missing")

endmodule

// File: rtl/prt_ram.sv
module prt_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first: a read of the entry being written returns the old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: sim/partition_refinement_table_tb.sv
module partition_refinement_table_tb;
    import prt_pkg::*;

    localparam int TABLE_SIZE   = DEF_ELEMENTS;
    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT  = 400000;

    // the package leaves the fourth opcode unnamed; it must do nothing
    localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;

    typedef struct {
        t_in_item  stim;
        bit        known;
        t_out_item want;
    } t_directed_row;

    // receiver stall patterns
    typedef enum {RX_FREE, RX_COIN, RX_EVERY4, RX_SLOW} t_rx_pattern;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    // shadow copy of both maps, with a record of which entries were ever written
    logic [POS_W-1:0]   elem_at_pos [TABLE_SIZE];
    logic [POS_W-1:0]   pos_of_elem [TABLE_SIZE];
    bit                 pos_written [TABLE_SIZE];
    bit                 elem_placed [TABLE_SIZE];
    logic [PIVOT_W-1:0] blk_begin = '0;
    logic [PIVOT_W-1:0] blk_split = '0;

    t_out_item     splits_due[$];
    int            mismatches  = 0;
    int            items_sent  = 0;
    int            burst_left  = 0;
    int            cycle_count = 0;
    t_directed_row directed_rows[23];

    partition_refinement_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // one item through the table: updates the shadow state, returns the reply
    function automatic t_out_item predict_split(t_in_item it);
        t_out_item        res;
        logic [POS_W-1:0] at;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] ea;
        logic [POS_W-1:0] eb;
        res.moved = 1'b0;
        case (it.opcode)
            OP_PLACE: begin
                elem_at_pos[it.position] = it.element;
                pos_of_elem[it.element]  = it.position;
                pos_written[it.position] = 1'b1;
                elem_placed[it.element]  = 1'b1;
            end
            OP_START: begin
                blk_begin = {1'b0, it.position};
                blk_split = (it.range_end > TABLE_SIZE) ? PIVOT_W'(TABLE_SIZE) : it.range_end;
            end
            OP_MARK: begin
                at = pos_of_elem[it.element];
                if ({1'b0, at} >= blk_begin && {1'b0, at} < blk_split) begin
                    // element joins the new block: swap it with the entry at the new split
                    blk_split = blk_split - 1'b1;
                    lo = blk_split[POS_W-1:0];
                    ea = elem_at_pos[at];
                    eb = elem_at_pos[lo];
                    elem_at_pos[at] = eb;
                    elem_at_pos[lo] = ea;
                    pos_of_elem[ea] = lo;
                    pos_of_elem[eb] = at;
                    res.moved = 1'b1;
                end
            end
            default: ;
        endcase
        res.pivot = blk_split;
        return res;
    endfunction

    // a mark must only look up entries that were written, the swap partner included
    function automatic bit mark_is_safe(logic [ELEM_W-1:0] e);
        return elem_placed[e] &&
               (blk_split == '0 || pos_written[blk_split[POS_W-1:0] - 1'b1]);
    endfunction

    function automatic t_in_item pack_item(logic [OPCODE_W-1:0] op, logic [ELEM_W-1:0] e,
                                           logic [POS_W-1:0] p, logic [END_W-1:0] stop);
        t_in_item it;
        it.opcode    = op;
        it.element   = e;
        it.position  = p;
        it.range_end = stop;
        return it;
    endfunction

    function automatic t_directed_row row(logic [OPCODE_W-1:0] op, int e, int p, int stop,
                                          bit known, int pv, bit mv);
        t_directed_row r;
        r.stim       = pack_item(op, ELEM_W'(e), POS_W'(p), END_W'(stop));
        r.known      = known;
        r.want.pivot = PIVOT_W'(pv);
        r.want.moved = mv;
        return r;
    endfunction

    // offer one item, called at a falling edge; returns at the falling edge after the transfer
    task automatic offer(t_in_item it, bit known, t_out_item want);
        t_out_item predicted;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_split(it);
        splits_due.push_back(known ? want : predicted);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // fill a block with a shuffled set of elements, open it, then mark elements at random
    task automatic refine_phase();
        int                n;
        int                base;
        int                j;
        int                tmp;
        int                order[$];
        logic [ELEM_W-1:0] members[$];
        logic [ELEM_W-1:0] e;
        logic [POS_W-1:0]  first;
        logic [END_W-1:0]  stop;
        t_out_item         none;
        none = '0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 128) : $urandom_range(1, 32);
        case ($urandom_range(0, 9))
            0:       base = 0;
            1:       base = TABLE_SIZE - n;
            default: base = $urandom_range(0, TABLE_SIZE - n);
        endcase
        for (int i = 0; i < n; i++) order.push_back(i);
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i]) begin
            case ($urandom_range(0, 15))
                0: offer(pack_item(OP_NONE, ELEM_W'($urandom), POS_W'($urandom),
                                   END_W'($urandom)), 1'b0, none);
                1: offer(pack_item(OP_PLACE, ELEM_W'($urandom), POS_W'($urandom),
                                   END_W'($urandom)), 1'b0, none);
                default: ;
            endcase
            e = ELEM_W'($urandom);
            members.push_back(e);
            offer(pack_item(OP_PLACE, e, POS_W'(base + order[i]), END_W'($urandom)),
                  1'b0, none);
        end
        // mostly the exact block; otherwise a narrowed, saturated or inverted range
        case ($urandom_range(0, 9))
            6: begin
                first = POS_W'(base + $urandom_range(0, n - 1));
                stop  = END_W'(base + n);
            end
            7: begin
                first = POS_W'(base);
                stop  = (base + n == TABLE_SIZE) ? END_W'($urandom_range(TABLE_SIZE, 2047))
                                                 : END_W'(base + n);
            end
            8: begin
                first = POS_W'(base + n - 1);
                stop  = END_W'(base);
            end
            9: begin
                first = POS_W'(base);
                stop  = END_W'(base + $urandom_range(0, n));
            end
            default: begin
                first = POS_W'(base);
                stop  = END_W'(base + n);
            end
        endcase
        offer(pack_item(OP_START, ELEM_W'($urandom), first, stop), 1'b0, none);
        repeat ($urandom_range(1, n + n / 2 + 1)) begin
            e = ($urandom_range(0, 6) != 0) ? members[$urandom_range(0, members.size() - 1)]
                                            : ELEM_W'($urandom);
            if (!elem_placed[e]) e = members[$urandom_range(0, members.size() - 1)];
            if (mark_is_safe(e))
                offer(pack_item(OP_MARK, e, POS_W'($urandom), END_W'($urandom)), 1'b0, none);
            else
                offer(pack_item(OP_NONE, ELEM_W'($urandom), POS_W'($urandom),
                                END_W'($urandom)), 1'b0, none);
        end
    endtask

    // receiver: switches between stall patterns every so often
    initial begin
        t_rx_pattern pattern;
        int          pattern_left;
        pattern = RX_FREE;
        pattern_left = 0;
        forever begin
            @(negedge i_clk);
            if (pattern_left == 0) begin
                pattern = t_rx_pattern'($urandom_range(0, 3));
                pattern_left = $urandom_range(20, 150);
            end
            pattern_left--;
            case (pattern)
                RX_FREE:   i_out_ready <= 1'b1;
                RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                RX_EVERY4: i_out_ready <= (pattern_left % 4 == 0);
                default:   i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // each result transfer against the oldest reply still due
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (splits_due.size() == 0) begin
                mismatches++;
                $display("%0t: result with none due, got pivot %0d moved %0b",
                         $time, o_out_data.pivot, o_out_data.moved);
            end else begin
                want = splits_due.pop_front();
                if (o_out_data.pivot !== want.pivot) begin
                    mismatches++;
                    $display("%0t: pivot expected %0d got %0d",
                             $time, want.pivot, o_out_data.pivot);
                end
                if (o_out_data.moved !== want.moved) begin
                    mismatches++;
                    $display("%0t: moved expected %0b got %0b",
                             $time, want.moved, o_out_data.moved);
                end
            end
        end
    end

    initial begin
        // extremes, saturation, inverted range, unused opcode, marks in and out of the block
        directed_rows[0]  = row(OP_NONE,     0,    0,    0, 1'b1,    0, 1'b0);
        directed_rows[1]  = row(OP_PLACE, 1023, 1023,    0, 1'b1,    0, 1'b0);
        directed_rows[2]  = row(OP_PLACE,    0,    0, 2047, 1'b1,    0, 1'b0);
        directed_rows[3]  = row(OP_PLACE,    5, 1022,    0, 1'b1,    0, 1'b0);
        directed_rows[4]  = row(OP_PLACE,    7, 1021,    0, 1'b1,    0, 1'b0);
        directed_rows[5]  = row(OP_START,    0,    0, 2047, 1'b1, 1024, 1'b0);
        directed_rows[6]  = row(OP_MARK,  1023,    0,    0, 1'b1, 1023, 1'b1);
        directed_rows[7]  = row(OP_MARK,  1023,    0,    0, 1'b1, 1023, 1'b0);
        directed_rows[8]  = row(OP_MARK,     5,    0,    0, 1'b0,    0, 1'b0);
        directed_rows[9]  = row(OP_MARK,     0,    0,    0, 1'b0,    0, 1'b0);
        directed_rows[10] = row(OP_NONE,  1023, 1023, 2047, 1'b1, 1021, 1'b0);
        directed_rows[11] = row(OP_START,    0, 1023,    0, 1'b1,    0, 1'b0);
        directed_rows[12] = row(OP_MARK,     7,    0,    0, 1'b1,    0, 1'b0);
        directed_rows[13] = row(OP_START,    0, 1023, 1024, 1'b1, 1024, 1'b0);
        directed_rows[14] = row(OP_MARK,     0,    0,    0, 1'b1, 1024, 1'b0);
        directed_rows[15] = row(OP_MARK,     5,    0,    0, 1'b1, 1024, 1'b0);
        directed_rows[16] = row(OP_START,    0,    0, 1024, 1'b1, 1024, 1'b0);
        directed_rows[17] = row(OP_MARK,     7,    0,    0, 1'b0,    0, 1'b0);
        directed_rows[18] = row(OP_START,    0, 1021, 1023, 1'b1, 1023, 1'b0);
        directed_rows[19] = row(OP_MARK,     0,    0,    0, 1'b0,    0, 1'b0);
        directed_rows[20] = row(OP_MARK,     5,    0,    0, 1'b0,    0, 1'b0);
        directed_rows[21] = row(OP_MARK,     5,    0,    0, 1'b0,    0, 1'b0);
        directed_rows[22] = row(OP_START,    0,  512, 1536, 1'b1, 1024, 1'b0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].want);
        while (items_sent < RANDOM_ITEMS + $size(directed_rows)) refine_phase();
        i_in_valid <= 1'b0;

        // drain, then keep watching for anything stray before the verdict
        while (splits_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
